// ===== design/hpb_pkg.sv =====
// shared types, codes and constants of the histogram percentile bounds block
`timescale 1ns / 1ps
`default_nettype none

package hpb_pkg;

  localparam int NUM_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_W         = 17;
  localparam int VAL_W          = 17;
  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 3;
  localparam logic [VAL_W-1:0] VAL_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_BOUNDS = 3'd2,
    OP_QUANT  = 3'd3,
    OP_READ   = 3'd4,
    OP_ACCUM  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SKIP  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALUE  = 3'd0,
    REG_BIN_SHIFT  = 3'd1,
    REG_LOWER_FRAC = 3'd2,
    REG_UPPER_FRAC = 3'd3,
    REG_ROI_X_MIN  = 3'd4,
    REG_ROI_X_MAX  = 3'd5,
    REG_ROI_Y_MIN  = 3'd6,
    REG_ROI_Y_MAX  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_ADD_WB,
    S_READ_WB,
    S_MUL,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] pixel_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        pixel_enable;
    logic [16:0] probability;
    logic [7:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [16:0] lower_bound;
    logic [16:0] upper_bound;
    logic [31:0] total_count;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic accum;
  } walk_ctrl_t;

  typedef struct packed {
    logic active;
    logic done;
  } walk_stat_t;

endpackage

`default_nettype wire

// ===== design/histogram_percentile_bounds.sv =====
// top level of the histogram engine with percentile bounds and quantiles
// Single-band histogram over a bin memory of NUM_BINS counters. A command is taken when start is
// high and busy is low; each command gives exactly one result, shown for one cycle with
// out_strobe, and the receiver cannot stall it. All bin traffic goes through the one
// read-modify-write path of the bin memory (registered read), which sets the timing: a pixel
// add reads its bin and writes it back, a bin read reads and answers; a skipped or rejected
// pixel, a bin read out of range, a query on an empty histogram and unused opcodes answer
// from dispatch; clear sweeps every bin, make cumulative walks the bins, and bounds or
// quantile run the threshold multiply, then walk one bin per cycle. After reset the memory
// is swept to zero with busy high; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module histogram_percentile_bounds import hpb_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  output logic                      out_strobe,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int PW = COUNT_BITS + FRAC_W;
  localparam int EW = COUNT_BITS + 32;
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

  logic [15:0] min_value_r;
  logic [3:0]  bin_shift_r;
  logic [16:0] lower_frac_r;
  logic [16:0] upper_frac_r;
  logic [12:0] roi_x_min_r;
  logic [12:0] roi_x_max_r;
  logic [12:0] roi_y_min_r;
  logic [12:0] roi_y_max_r;

  state_t                state_r, state_nxt;
  in_item_t              item_r;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic                  out_strobe_r;
  out_item_t             out_item_r;
  logic                  emit;
  out_item_t             res;

  op_t                   op;
  logic                  roi_ok;
  logic                  below_min;
  logic [15:0]           diff;
  logic [15:0]           bin_wide;
  logic                  bin_over;
  logic [AW-1:0]         add_addr;
  logic                  idx_ok;
  logic [COUNT_BITS-1:0] inc_cnt;

  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [COUNT_BITS-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [COUNT_BITS-1:0] mem_wr_data;

  logic                  mul_start;
  logic [FRAC_W-1:0]     lo_frac;
  logic [PW-1:0]         prod_lo;
  logic [PW-1:0]         prod_hi;
  logic                  mul_done;
  logic                  mul_hi_done;

  walk_ctrl_t            wctl;
  walk_stat_t            wstat;
  logic                  walk_rd_en;
  logic [AW-1:0]         walk_rd_addr;
  logic                  walk_wr_en;
  logic [AW-1:0]         walk_wr_addr;
  logic [COUNT_BITS-1:0] walk_wr_data;
  logic [VAL_W-1:0]      walk_lo;
  logic [VAL_W-1:0]      walk_hi;

  function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    if (e > EW'(32'hFFFF_FFFF)) begin
      sat32 = '1;
    end else begin
      sat32 = e[31:0];
    end
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    if (&v) begin
      sat_inc = v;
    end else begin
      sat_inc = v + COUNT_BITS'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r  <= 16'd0;
      bin_shift_r  <= 4'd0;
      lower_frac_r <= 17'd655;
      upper_frac_r <= 17'd64881;
      roi_x_min_r  <= 13'd0;
      roi_x_max_r  <= 13'd4096;
      roi_y_min_r  <= 13'd0;
      roi_y_max_r  <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_VALUE:  min_value_r  <= cfg_wdata[15:0];
        REG_BIN_SHIFT:  bin_shift_r  <= cfg_wdata[3:0];
        REG_LOWER_FRAC: lower_frac_r <= cfg_wdata[16:0];
        REG_UPPER_FRAC: upper_frac_r <= cfg_wdata[16:0];
        REG_ROI_X_MIN:  roi_x_min_r  <= cfg_wdata[12:0];
        REG_ROI_X_MAX:  roi_x_max_r  <= cfg_wdata[12:0];
        REG_ROI_Y_MIN:  roi_y_min_r  <= cfg_wdata[12:0];
        REG_ROI_Y_MAX:  roi_y_max_r  <= cfg_wdata[12:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_r        <= '0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    out_item_r <= res;
  end

  // pixel decode
  assign op        = op_t'(item_r.opcode);
  assign roi_ok    = item_r.pixel_enable
                     && ({1'b0, item_r.pixel_x} >= roi_x_min_r)
                     && ({1'b0, item_r.pixel_x} <  roi_x_max_r)
                     && ({1'b0, item_r.pixel_y} >= roi_y_min_r)
                     && ({1'b0, item_r.pixel_y} <  roi_y_max_r);
  assign below_min = item_r.pixel_value < min_value_r;
  assign diff      = item_r.pixel_value - min_value_r;
  assign bin_wide  = diff >> bin_shift_r;
  assign bin_over  = 17'(bin_wide) >= 17'(NUM_BINS);
  assign add_addr  = AW'(bin_wide);
  assign idx_ok    = 13'(item_r.bin_index) < 13'(NUM_BINS);
  assign inc_cnt   = sat_inc(mem_rd_data);
  assign lo_frac   = (op == OP_QUANT) ? item_r.probability : lower_frac_r;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    total_nxt       = total_r;
    emit            = 1'b0;
    res             = '0;
    res.total_count = sat32(total_r);
    mul_start       = 1'b0;
    wctl            = '0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = walk_rd_addr;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = clr_r;
    mem_wr_data     = '0;
    unique case (state_r)
      S_INIT: begin
        mem_wr_en = 1'b1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_BIN) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op)
          OP_CLEAR: begin
            total_nxt = '0;
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          OP_ADD: begin
            priority if (!roi_ok) begin
              emit       = 1'b1;
              res.status = STAT_SKIP;
              state_nxt  = S_IDLE;
            end else if (below_min || bin_over) begin
              emit       = 1'b1;
              res.status = STAT_RANGE;
              state_nxt  = S_IDLE;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = add_addr;
              state_nxt   = S_ADD_WB;
            end
          end
          OP_BOUNDS, OP_QUANT: begin
            if (total_r == '0) begin
              emit       = 1'b1;
              res.status = STAT_EMPTY;
              state_nxt  = S_IDLE;
            end else begin
              mul_start = 1'b1;
              state_nxt = S_MUL;
            end
          end
          OP_READ: begin
            if (idx_ok) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(item_r.bin_index);
              state_nxt   = S_READ_WB;
            end else begin
              emit       = 1'b1;
              res.status = STAT_RANGE;
              state_nxt  = S_IDLE;
            end
          end
          OP_ACCUM: begin
            wctl.start = 1'b1;
            wctl.accum = 1'b1;
            state_nxt  = S_WALK;
          end
          default: begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CLEAR: begin
        mem_wr_en = 1'b1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_BIN) begin
          clr_nxt   = '0;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ADD_WB: begin
        mem_wr_en       = 1'b1;
        mem_wr_addr     = add_addr;
        mem_wr_data     = inc_cnt;
        total_nxt       = sat_inc(total_r);
        emit            = 1'b1;
        res.bin_count   = sat32(inc_cnt);
        res.total_count = sat32(total_nxt);
        state_nxt       = S_IDLE;
      end
      S_READ_WB: begin
        emit          = 1'b1;
        res.bin_count = sat32(mem_rd_data);
        state_nxt     = S_IDLE;
      end
      S_MUL: begin
        if (mul_done) begin
          wctl.start = 1'b1;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        mem_rd_en   = walk_rd_en;
        mem_rd_addr = walk_rd_addr;
        mem_wr_en   = walk_wr_en;
        mem_wr_addr = walk_wr_addr;
        mem_wr_data = walk_wr_data;
        if (wstat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        emit = 1'b1;
        if (op == OP_BOUNDS) begin
          res.lower_bound = walk_lo;
          res.upper_bound = walk_hi;
        end else if (op == OP_QUANT) begin
          res.lower_bound = walk_lo;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  hpb_bin_mem #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  hpb_frac_mul #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mul_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .frac    (lo_frac),
    .total   (total_r),
    .product (prod_lo),
    .done    (mul_done)
  );

  hpb_frac_mul #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mul_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .frac    (upper_frac_r),
    .total   (total_r),
    .product (prod_hi),
    .done    (mul_hi_done)
  );

  hpb_walker #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (wctl),
    .stat      (wstat),
    .min_value (min_value_r),
    .bin_shift (bin_shift_r),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .rd_en     (walk_rd_en),
    .rd_addr   (walk_rd_addr),
    .rd_data   (mem_rd_data),
    .wr_en     (walk_wr_en),
    .wr_addr   (walk_wr_addr),
    .wr_data   (walk_wr_data),
    .lo_bound  (walk_lo),
    .hi_bound  (walk_hi)
  );

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result strobes in a row");

  a_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("bin memory read and write hit the same entry");

  a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
    wstat.active |-> (state_r == S_WALK))
    else $error("bin walk running outside the walk state");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    wstat.done |-> wstat.active)
    else $error("walk finished without running");

  a_mul_sync: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (mul_hi_done && state_r == S_MUL))
    else $error("threshold products out of step with the controller");

endmodule

`default_nettype wire

// ===== design/hpb_bin_mem.sv =====
// bin counter memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hpb_bin_mem import hpb_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(NUM_BINS)-1:0] rd_addr,
  output logic      [COUNT_BITS-1:0]       rd_data,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(NUM_BINS)-1:0] wr_addr,
  input  wire logic [COUNT_BITS-1:0]       wr_data
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/hpb_frac_mul.sv =====
// two-stage fraction times total product for the percentile threshold
`timescale 1ns / 1ps
`default_nettype none

module hpb_frac_mul import hpb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [FRAC_W-1:0]            frac,
  input  wire logic [COUNT_BITS-1:0]        total,
  output logic      [COUNT_BITS+FRAC_W-1:0] product,
  output logic                              done
);

  localparam int PW = COUNT_BITS + FRAC_W;
  localparam int HW = (COUNT_BITS + 1) / 2;
  localparam int UW = COUNT_BITS - HW;
  localparam int LW = FRAC_W + HW;
  localparam int MW = FRAC_W + UW;

  logic [LW-1:0] p_lo_r;
  logic [MW-1:0] p_hi_r;
  logic [PW-1:0] prod_r;
  logic          v1_r;
  logic          v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // split the total in two halves to keep each multiplier narrow
  always_ff @(posedge clk) begin
    if (start) begin
      p_lo_r <= LW'(frac) * LW'(total[HW-1:0]);
      p_hi_r <= MW'(frac) * MW'(total[COUNT_BITS-1:HW]);
    end
    if (v1_r) begin
      prod_r <= PW'(p_lo_r) + (PW'(p_hi_r) << HW);
    end
  end

  assign product = prod_r;
  assign done    = v2_r;

endmodule

`default_nettype wire

// ===== design/hpb_walker.sv =====
// sequential bin walk for percentile bounds, quantiles and cumulative conversion
`timescale 1ns / 1ps
`default_nettype none

module hpb_walker import hpb_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire walk_ctrl_t                   ctrl,
  output walk_stat_t                        stat,
  input  wire logic [15:0]                  min_value,
  input  wire logic [3:0]                   bin_shift,
  input  wire logic [COUNT_BITS+FRAC_W-1:0] prod_lo,
  input  wire logic [COUNT_BITS+FRAC_W-1:0] prod_hi,
  output logic                              rd_en,
  output logic [$clog2(NUM_BINS)-1:0]       rd_addr,
  input  wire logic [COUNT_BITS-1:0]        rd_data,
  output logic                              wr_en,
  output logic [$clog2(NUM_BINS)-1:0]       wr_addr,
  output logic [COUNT_BITS-1:0]             wr_data,
  output logic [VAL_W-1:0]                  lo_bound,
  output logic [VAL_W-1:0]                  hi_bound
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int PW = COUNT_BITS + FRAC_W;
  localparam int BW = AW + 17;
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

  logic                  active_r;
  logic                  accum_r;
  logic [AW:0]           iss_r;
  logic                  dv_r;
  logic [AW-1:0]         dbin_r;
  logic [COUNT_BITS-1:0] cum_r;
  logic [VAL_W-1:0]      lo_r;
  logic [VAL_W-1:0]      hi_r;
  logic [COUNT_BITS:0]   cum_sum;
  logic [COUNT_BITS-1:0] cum_nxt;
  logic [PW-1:0]         cum_scaled;
  logic                  below_lo;
  logic                  below_hi;
  logic [VAL_W-1:0]      dbin_val;

  function automatic logic [VAL_W-1:0] bin_val(input logic [AW-1:0] b,
                                               input logic [3:0]   sh,
                                               input logic [15:0]  mv);
    logic [BW-1:0] v;
    v = (BW'(b) << sh) + BW'(mv);
    if (v > BW'(VAL_MAX)) begin
      bin_val = VAL_MAX;
    end else begin
      bin_val = v[VAL_W-1:0];
    end
  endfunction

  assign rd_en   = active_r && (iss_r < (AW+1)'(NUM_BINS));
  assign rd_addr = iss_r[AW-1:0];

  assign cum_sum    = {1'b0, cum_r} + {1'b0, rd_data};
  assign cum_nxt    = cum_sum[COUNT_BITS] ? '1 : cum_sum[COUNT_BITS-1:0];
  assign cum_scaled = PW'({cum_nxt, 16'h0000});
  assign below_lo   = cum_scaled < prod_lo;
  assign below_hi   = cum_scaled < prod_hi;
  assign dbin_val   = bin_val(dbin_r, bin_shift, min_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      dv_r     <= 1'b0;
    end else begin
      dv_r <= rd_en;
      if (ctrl.start) begin
        active_r <= 1'b1;
      end else if (stat.done) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dbin_r <= rd_addr;
    if (ctrl.start) begin
      accum_r <= ctrl.accum;
      iss_r   <= '0;
      cum_r   <= '0;
      lo_r    <= '0;
      hi_r    <= bin_val(LAST_BIN, bin_shift, min_value);
    end else begin
      if (rd_en) begin
        iss_r <= iss_r + (AW+1)'(1);
      end
      if (dv_r) begin
        cum_r <= cum_nxt;
        if (below_lo) begin
          lo_r <= dbin_val;
        end
        if (below_hi) begin
          hi_r <= dbin_val;
        end
      end
    end
  end

  assign wr_en   = dv_r && accum_r;
  assign wr_addr = dbin_r;
  assign wr_data = cum_nxt;

  assign stat.active = active_r;
  assign stat.done   = dv_r && (dbin_r == LAST_BIN);

  assign lo_bound = lo_r;
  assign hi_bound = hi_r;

endmodule

`default_nettype wire
